[src/assert_macros.svh]
// Assertion macros shared by the checker files of the sorted note event list.
// No dependencies; include this header by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define SNEL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property check failed");

// Checked at every rising edge, reset included.
`define SNEL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: property check failed");

`endif

[src/snel_pkg.sv]
// Package of the sorted note event list: sizes, codes, beat and event types.
// No dependencies; the module files refer to it by scoped names.
package snel_pkg;

  localparam int DEPTH         = 256;
  localparam int POSITION_BITS = 24;

  localparam int POS_W = POSITION_BITS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Width wide enough to compare the 8-bit slot index against counts and indexes.
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [1:0] {
    OP_INSERT       = 2'd0,
    OP_REMOVE_MATCH = 2'd1,
    OP_REMOVE_AT    = 2'd2,
    OP_CLEAR        = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_APPLY
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [23:0] position;
    logic        note_on;
    logic [6:0]  pitch;
    logic [7:0]  velocity;
    logic [7:0]  slot_index;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] affected_index;
    logic [8:0] entry_count;
  } out_beat_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             note_on;
    logic [6:0]       pitch;
    logic [7:0]       velocity;
  } event_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

  function automatic event_t make_event(input in_beat_t b);
    event_t e;
    e.position = POS_W'(b.position);
    e.note_on  = b.note_on;
    e.pitch    = b.pitch;
    e.velocity = b.velocity;
    return e;
  endfunction

endpackage

[src/snel_cell.sv]
// One storage cell of the sorted event chain: holds an event, compares it
// against the incoming one and shifts with its neighbors. Uses snel_pkg.
module snel_cell (
  input  logic                 clk,
  input  snel_pkg::cell_ctrl_t ctrl,
  input  snel_pkg::event_t     new_ev,
  input  snel_pkg::event_t     left_ev,
  input  snel_pkg::event_t     right_ev,
  input  logic                 t_self,
  input  logic                 t_left,
  output snel_pkg::event_t     ev_q,
  output logic                 ge_q,
  output logic                 eq_q
);

  snel_pkg::event_t ev_r;
  snel_pkg::event_t ev_nxt;
  logic             ge_r;
  logic             eq_r;

  // On insert the cells past the insertion point take their left neighbor and
  // the first marked cell takes the new event; on delete the marked cells take
  // their right neighbor.
  always_comb begin
    ev_nxt = ev_r;
    if (ctrl.ins_en) begin
      if (t_left) begin
        ev_nxt = left_ev;
      end else if (t_self) begin
        ev_nxt = new_ev;
      end
    end else if (ctrl.del_en && t_self) begin
      ev_nxt = right_ev;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
    if (ctrl.cmp_en) begin
      ge_r <= (ev_r.position >= new_ev.position);
      eq_r <= (ev_r == new_ev);
    end
  end

  assign ev_q = ev_r;
  assign ge_q = ge_r;
  assign eq_q = eq_r;

endmodule

[src/snel_find.sv]
// Locator of the sorted event chain: turns the cell flags into a thermometer
// mask of the cells that move. Uses snel_pkg.
module snel_find (
  input  logic                          clk,
  input  logic                          en,
  input  snel_pkg::op_t                 op,
  input  logic [snel_pkg::CNT_W-1:0]    count,
  input  logic [7:0]                    slot,
  input  logic [snel_pkg::DEPTH-1:0]    ge_vec,
  input  logic [snel_pkg::DEPTH-1:0]    eq_vec,
  output logic [snel_pkg::DEPTH-1:0]    therm_q
);

  localparam int Depth = snel_pkg::DEPTH;
  localparam int IdxW  = snel_pkg::IDX_W;
  localparam int CntW  = snel_pkg::CNT_W;
  localparam int CmpW  = snel_pkg::CMP_W;

  logic [Depth-1:0] occ;
  logic [Depth-1:0] at_count;
  logic [Depth-1:0] from_slot;
  logic [Depth-1:0] prefix;
  logic [Depth-1:0] therm_r;
  logic [Depth-1:0] therm_nxt;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      occ[i]       = (CntW'(i) < count);
      at_count[i]  = (CntW'(i) == count);
      from_slot[i] = (CmpW'(i) >= CmpW'(slot));
    end
  end

  // Parallel prefix OR marks every cell at or after the first match.
  always_comb begin
    prefix = occ & eq_vec;
    for (int lvl = 0; lvl < IdxW; lvl++) begin
      prefix = prefix | (prefix << (1 << lvl));
    end
  end

  always_comb begin
    case (op)
      snel_pkg::OP_INSERT:       therm_nxt = (occ & ge_vec) | at_count;
      snel_pkg::OP_REMOVE_MATCH: therm_nxt = prefix;
      default:                   therm_nxt = from_slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      therm_r <= therm_nxt;
    end
  end

  assign therm_q = therm_r;

endmodule

[src/sorted_note_event_list.sv]
// Top level of the sorted note event list: control, count and result beat.
// Uses snel_pkg, snel_cell and snel_find.
//
// Usage. One input channel (in_valid, in_stall, in_data) carries operation
// beats: insert, remove matching, remove at index and clear. One result
// channel (out_valid, out_stall, out_data) returns exactly one beat per
// operation with a status, the affected index and the new entry count.
// A beat moves at a rising edge where valid is high and stall is low.
// Each operation passes through these steps in order: the compare in every
// cell at the accepting edge, the locate pass in S_FIND that builds the move
// mask, and the shift of the cell chain in S_APPLY that commits the operation
// and registers its result beat. A new operation is taken only in S_IDLE,
// after the previous one has committed.
// A finished result waits in the output register, so the next operation is
// accepted while the receiver stalls; only if a second result is ready while
// the first is still held does the commit cycle wait.
// Reset (synchronous, rst_n low) empties the list, drops any pending result
// and stalls the input. The cell contents need no reset since only cells
// below the count are ever read.
module sorted_note_event_list (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  snel_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output snel_pkg::out_beat_t out_data
);

  localparam int Depth = snel_pkg::DEPTH;
  localparam int IdxW  = snel_pkg::IDX_W;
  localparam int CntW  = snel_pkg::CNT_W;
  localparam int CmpW  = snel_pkg::CMP_W;

  snel_pkg::state_t    state_r;
  snel_pkg::state_t    state_nxt;
  snel_pkg::in_beat_t  req_r;
  logic [CntW-1:0]     count_r;
  logic [CntW-1:0]     count_nxt;
  logic                out_valid_r;
  snel_pkg::out_beat_t out_data_r;
  snel_pkg::out_beat_t result;

  snel_pkg::cell_ctrl_t ctrl;
  snel_pkg::event_t     new_ev;
  snel_pkg::event_t     cell_ev [Depth];
  logic [Depth-1:0]     ge_vec;
  logic [Depth-1:0]     eq_vec;
  logic [Depth-1:0]     therm;

  logic            accept;
  logic            find_en;
  logic            commit;
  logic            full;
  logic            found;
  logic            bad_index;
  logic [IdxW-1:0] hit_idx;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      snel_pkg::S_IDLE:  if (in_valid) state_nxt = snel_pkg::S_FIND;
      snel_pkg::S_FIND:  state_nxt = snel_pkg::S_APPLY;
      snel_pkg::S_APPLY: if (!(out_valid_r && out_stall)) state_nxt = snel_pkg::S_IDLE;
      default:           state_nxt = snel_pkg::S_IDLE;
    endcase
  end

  // State outputs. The input stays stalled while reset is held.
  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    find_en  = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      snel_pkg::S_IDLE: begin
        in_stall = !rst_n;
        accept   = in_valid && rst_n;
      end
      snel_pkg::S_FIND:  find_en = 1'b1;
      snel_pkg::S_APPLY: commit  = !(out_valid_r && out_stall);
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // The cells compare against the incoming beat in the accept cycle; afterwards
  // new_ev carries the held request, which an insert writes into the chain.
  assign new_ev = accept ? snel_pkg::make_event(in_data) : snel_pkg::make_event(req_r);

  assign full      = (count_r == CntW'(Depth));
  assign found     = therm[Depth-1];
  assign bad_index = (CmpW'(req_r.slot_index) >= CmpW'(count_r));

  // The first set bit of the move mask is the affected index.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < Depth; i++) begin
      if (therm[i] && (i == 0 || !therm[(i == 0) ? 0 : i - 1])) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
  end

  always_comb begin
    ctrl.cmp_en = accept;
    ctrl.ins_en = 1'b0;
    ctrl.del_en = 1'b0;
    count_nxt   = count_r;
    result.status         = snel_pkg::ST_OK;
    result.affected_index = '0;
    unique case (req_r.operation)
      snel_pkg::OP_INSERT: begin
        if (full) begin
          result.status = snel_pkg::ST_FULL;
        end else begin
          ctrl.ins_en           = commit;
          count_nxt             = count_r + CntW'(1);
          result.affected_index = 8'(hit_idx);
        end
      end
      snel_pkg::OP_REMOVE_MATCH: begin
        if (!found) begin
          result.status = snel_pkg::ST_NOT_FOUND;
        end else begin
          ctrl.del_en           = commit;
          count_nxt             = count_r - CntW'(1);
          result.affected_index = 8'(hit_idx);
        end
      end
      snel_pkg::OP_REMOVE_AT: begin
        if (bad_index) begin
          result.status = snel_pkg::ST_BAD_INDEX;
        end else begin
          ctrl.del_en           = commit;
          count_nxt             = count_r - CntW'(1);
          result.affected_index = 8'(hit_idx);
        end
      end
      snel_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    result.entry_count = 9'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= snel_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (commit) begin
      out_data_r <= result;
    end
  end

  // The chain of cells; the ends see themselves as their outer neighbor.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    snel_pkg::event_t left_ev;
    snel_pkg::event_t right_ev;
    logic             t_left;
    if (g == 0) begin : g_first
      assign left_ev = cell_ev[g];
      assign t_left  = 1'b0;
    end else begin : g_inner_left
      assign left_ev = cell_ev[g-1];
      assign t_left  = therm[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign right_ev = cell_ev[g];
    end else begin : g_inner_right
      assign right_ev = cell_ev[g+1];
    end
    snel_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_ev   (new_ev),
      .left_ev  (left_ev),
      .right_ev (right_ev),
      .t_self   (therm[g]),
      .t_left   (t_left),
      .ev_q     (cell_ev[g]),
      .ge_q     (ge_vec[g]),
      .eq_q     (eq_vec[g])
    );
  end

  snel_find u_find (
    .clk     (clk),
    .en      (find_en),
    .op      (req_r.operation),
    .count   (count_r),
    .slot    (req_r.slot_index),
    .ge_vec  (ge_vec),
    .eq_vec  (eq_vec),
    .therm_q (therm)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/snel_checker.sv]
// Port-level checks for the sorted note event list, bound to its top level.
// Uses snel_pkg and assert_macros.svh.
`include "assert_macros.svh"

module snel_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input snel_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input snel_pkg::out_beat_t out_data
);

  logic in_beat;

  assign in_beat = in_valid && !in_stall && (in_data.operation == in_data.operation);

  // A held result stays put while the receiver stalls.
  `SNEL_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))
  // Reset drops any pending result.
  `SNEL_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid)
  // The block is busy with an operation right after taking it.
  `SNEL_ASSERT(a_busy_after_beat, clk, rst_n, in_beat |=> in_stall)
  // A failed operation reports no affected index.
  `SNEL_ASSERT(a_fail_no_index, clk, rst_n, out_valid && out_data.status != snel_pkg::ST_OK |-> out_data.affected_index == 8'd0)
  // A full report comes only with a full list.
  `SNEL_ASSERT(a_full_count, clk, rst_n, out_valid && out_data.status == snel_pkg::ST_FULL |-> out_data.entry_count == 9'(snel_pkg::DEPTH))

endmodule

bind sorted_note_event_list snel_checker u_snel_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
